// ===== rtl/core/pic_pkg.sv =====
// ----------------------------------------------------------------------------
// pic_pkg
// Shared constants and register indexes of the point-in-cylinder test.
// ----------------------------------------------------------------------------
package pic_pkg;

  // Default coordinate width (signed fixed point)
  localparam int unsigned CoordBitsDef = 20;

  // Width of the configuration register index
  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_X  = 3'd0,
    CFG_START_Y  = 3'd1,
    CFG_START_Z  = 3'd2,
    CFG_END_X    = 3'd3,
    CFG_END_Y    = 3'd4,
    CFG_END_Z    = 3'd5,
    CFG_LEN_SQ   = 3'd6,
    CFG_RADIUS   = 3'd7
  } cfg_idx_e;

endpackage

// ===== rtl/core/point_in_cylinder_test_top.sv =====
// ----------------------------------------------------------------------------
// point_in_cylinder_test_top
// Capped-cylinder membership test for a stream of 3D points.
// ----------------------------------------------------------------------------
// Takes one point word per cycle while the output is not stalled and returns one
// result word per point, in order, through five stages for offsets, products,
// sums and the square of the dot product, a load stage and one stage per
// quotient bit of the pipelined divider that forms dot^2 / length_sq, and the
// output register. A stall at the output holds the whole pipeline.
// Configuration is taken at any time and must only change while idle.
module point_in_cylinder_test_top #(
  parameter int unsigned COORD_BITS = pic_pkg::CoordBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // point_x, point_y, point_z
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // dist_sq
  output logic [((2*COORD_BITS+10)/8)*8-1:0]   m_axis_tdata,
  // inside_res
  output logic                                 m_axis_tuser,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pic_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [2*COORD_BITS+1:0]              cfg_data_i
);

  localparam int unsigned QW   = 2 * COORD_BITS + 2;
  localparam int unsigned OW   = QW + 1;
  localparam int unsigned OTDW = ((2 * COORD_BITS + 10) / 8) * 8;

  logic signed [COORD_BITS-1:0] st_x_q, st_y_q, st_z_q, en_x_q, en_y_q, en_z_q;
  logic [QW-1:0]                len_q, rad_q;
  logic                         en;
  logic                         f_vld, s_vld, d_vld, s_out, d_out;
  logic signed [2*COORD_BITS+3:0] f_dot;
  logic [QW-1:0]                f_psq, s_psq, d_psq, d_quo, quo_eff;
  logic [2*QW-1:0]              s_num;
  logic [OW-1:0]                diff;
  logic                         inside_d;
  logic                         vld_q, inside_q;
  logic [OW-1:0]                dist_q;

  // Hold the pipeline while a result word waits
  assign en            = !vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_x_q <= '0;
      st_y_q <= '0;
      st_z_q <= '0;
      en_x_q <= '0;
      en_y_q <= '0;
      en_z_q <= '0;
      len_q  <= '0;
      rad_q  <= '0;
    end else if (cfg_valid_i) begin
      case (pic_pkg::cfg_idx_e'(cfg_index_i))
        pic_pkg::CFG_START_X: st_x_q <= cfg_data_i[COORD_BITS-1:0];
        pic_pkg::CFG_START_Y: st_y_q <= cfg_data_i[COORD_BITS-1:0];
        pic_pkg::CFG_START_Z: st_z_q <= cfg_data_i[COORD_BITS-1:0];
        pic_pkg::CFG_END_X:   en_x_q <= cfg_data_i[COORD_BITS-1:0];
        pic_pkg::CFG_END_Y:   en_y_q <= cfg_data_i[COORD_BITS-1:0];
        pic_pkg::CFG_END_Z:   en_z_q <= cfg_data_i[COORD_BITS-1:0];
        pic_pkg::CFG_LEN_SQ:  len_q  <= cfg_data_i;
        pic_pkg::CFG_RADIUS:  rad_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  pic_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .pt_x_i (s_axis_tdata[COORD_BITS-1:0]),
    .pt_y_i (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .pt_z_i (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .st_x_i (st_x_q),
    .st_y_i (st_y_q),
    .st_z_i (st_z_q),
    .en_x_i (en_x_q),
    .en_y_i (en_y_q),
    .en_z_i (en_z_q),
    .vld_o  (f_vld),
    .dot_o  (f_dot),
    .psq_o  (f_psq)
  );

  pic_sqr #(.COORD_BITS(COORD_BITS)) u_sqr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (f_vld),
    .dot_i     (f_dot),
    .psq_i     (f_psq),
    .len_sq_i  (len_q),
    .vld_o     (s_vld),
    .outside_o (s_out),
    .psq_o     (s_psq),
    .num_o     (s_num)
  );

  pic_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (s_vld),
    .outside_i (s_out),
    .psq_i     (s_psq),
    .num_i     (s_num),
    .den_i     (len_q),
    .vld_o     (d_vld),
    .outside_o (d_out),
    .psq_o     (d_psq),
    .quo_o     (d_quo)
  );

  // Zero axis length takes the quotient as zero
  assign quo_eff  = (len_q == '0) ? '0 : d_quo;
  assign diff     = {1'b0, d_psq} - {1'b0, quo_eff};
  assign inside_d = !d_out && (diff[OW-1] || (diff[QW-1:0] <= rad_q));

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_q <= inside_d;
      dist_q   <= inside_d ? diff : '0;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tuser  = inside_q;
  assign m_axis_tdata  = OTDW'(dist_q);

`ifndef SYNTH
  // A point that is not inside reports zero distance
  a_zero_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> dist_q == '0)
    else $error("nonzero distance on outside point");

  // A negative distance is always inside
  a_neg_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && dist_q[OW-1] |-> m_axis_tuser)
    else $error("negative distance flagged outside");

  // The quotient of a point between the caps never exceeds the squared axis length
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_vld && !d_out |-> quo_eff <= len_q)
    else $error("quotient above axis length");
`endif

endmodule

// ===== rtl/core/pic_front.sv =====
// ----------------------------------------------------------------------------
// pic_front
// Offsets, products and sums: three register stages giving dot and |pd|^2.
// ----------------------------------------------------------------------------
module pic_front #(
  parameter int unsigned COORD_BITS = pic_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic signed [COORD_BITS-1:0]  pt_x_i,
  input  logic signed [COORD_BITS-1:0]  pt_y_i,
  input  logic signed [COORD_BITS-1:0]  pt_z_i,
  input  logic signed [COORD_BITS-1:0]  st_x_i,
  input  logic signed [COORD_BITS-1:0]  st_y_i,
  input  logic signed [COORD_BITS-1:0]  st_z_i,
  input  logic signed [COORD_BITS-1:0]  en_x_i,
  input  logic signed [COORD_BITS-1:0]  en_y_i,
  input  logic signed [COORD_BITS-1:0]  en_z_i,
  output logic                          vld_o,
  output logic signed [2*COORD_BITS+3:0] dot_o,
  output logic [2*COORD_BITS+1:0]       psq_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * COORD_BITS + 2;
  localparam int unsigned SW = 2 * COORD_BITS + 4;

  logic signed [DW-1:0] px_d, py_d, pz_d, dx_d, dy_d, dz_d;
  logic signed [DW-1:0] px_q, py_q, pz_q, dx_q, dy_q, dz_q;
  logic signed [PW-1:0] mx_q, my_q, mz_q, sx_q, sy_q, sz_q;
  logic signed [SW-1:0] dot_d, dot_q;
  logic [PW-1:0]        psq_d, psq_q;
  logic [2:0]           vld_q;

  // Form offsets from the first cap centre
  assign px_d = $signed({pt_x_i[COORD_BITS-1], pt_x_i}) - $signed({st_x_i[COORD_BITS-1], st_x_i});
  assign py_d = $signed({pt_y_i[COORD_BITS-1], pt_y_i}) - $signed({st_y_i[COORD_BITS-1], st_y_i});
  assign pz_d = $signed({pt_z_i[COORD_BITS-1], pt_z_i}) - $signed({st_z_i[COORD_BITS-1], st_z_i});
  assign dx_d = $signed({en_x_i[COORD_BITS-1], en_x_i}) - $signed({st_x_i[COORD_BITS-1], st_x_i});
  assign dy_d = $signed({en_y_i[COORD_BITS-1], en_y_i}) - $signed({st_y_i[COORD_BITS-1], st_y_i});
  assign dz_d = $signed({en_z_i[COORD_BITS-1], en_z_i}) - $signed({st_z_i[COORD_BITS-1], st_z_i});

  // Sum the products
  assign dot_d = $signed({{2{mx_q[PW-1]}}, mx_q}) + $signed({{2{my_q[PW-1]}}, my_q})
               + $signed({{2{mz_q[PW-1]}}, mz_q});
  assign psq_d = $unsigned(sx_q) + $unsigned(sy_q) + $unsigned(sz_q);

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // Advance the data stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= px_d;
      py_q  <= py_d;
      pz_q  <= pz_d;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      dz_q  <= dz_d;
      mx_q  <= px_q * dx_q;
      my_q  <= py_q * dy_q;
      mz_q  <= pz_q * dz_q;
      sx_q  <= px_q * px_q;
      sy_q  <= py_q * py_q;
      sz_q  <= pz_q * pz_q;
      dot_q <= dot_d;
      psq_q <= psq_d;
    end
  end

  assign vld_o = vld_q[2];
  assign dot_o = dot_q;
  assign psq_o = psq_q;

endmodule

// ===== rtl/core/pic_sqr.sv =====
// ----------------------------------------------------------------------------
// pic_sqr
// Range check of dot against the squared axis length and the square of dot, built
// from half-width partial products over two register stages.
// ----------------------------------------------------------------------------
module pic_sqr #(
  parameter int unsigned COORD_BITS = pic_pkg::CoordBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  logic signed [2*COORD_BITS+3:0] dot_i,
  input  logic [2*COORD_BITS+1:0]        psq_i,
  input  logic [2*COORD_BITS+1:0]        len_sq_i,
  output logic                           vld_o,
  output logic                           outside_o,
  output logic [2*COORD_BITS+1:0]        psq_o,
  output logic [4*COORD_BITS+3:0]        num_o
);

  localparam int unsigned QW = 2 * COORD_BITS + 2;
  localparam int unsigned HW = COORD_BITS + 1;
  localparam int unsigned NW = 2 * QW;

  logic [QW-1:0] dot_u;
  logic [HW-1:0] dl, dh;
  logic          out_d;
  logic [QW-1:0] ll_q, lh_q, hh_q, psq1_q, psq2_q;
  logic          out1_q, out2_q;
  logic [NW-1:0] num_d, num_q;
  logic [1:0]    vld_q;

  // Reject points beyond either cap
  assign out_d = dot_i[2*COORD_BITS+3] || ($unsigned(dot_i) > {2'b00, len_sq_i});
  assign dot_u = dot_i[QW-1:0];
  assign dl    = dot_u[HW-1:0];
  assign dh    = dot_u[QW-1:HW];

  // Recombine the partial products
  assign num_d = {hh_q, ll_q} + ({{QW{1'b0}}, lh_q} << (HW + 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q   <= dl * dl;
      lh_q   <= dl * dh;
      hh_q   <= dh * dh;
      out1_q <= out_d;
      psq1_q <= psq_i;
      num_q  <= num_d;
      out2_q <= out1_q;
      psq2_q <= psq1_q;
    end
  end

  assign vld_o     = vld_q[1];
  assign outside_o = out2_q;
  assign psq_o     = psq2_q;
  assign num_o     = num_q;

endmodule

// ===== rtl/core/pic_div.sv =====
// ----------------------------------------------------------------------------
// pic_div
// Pipelined restoring divider: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module pic_div #(
  parameter int unsigned COORD_BITS = pic_pkg::CoordBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic                    outside_i,
  input  logic [2*COORD_BITS+1:0] psq_i,
  input  logic [4*COORD_BITS+3:0] num_i,
  input  logic [2*COORD_BITS+1:0] den_i,
  output logic                    vld_o,
  output logic                    outside_o,
  output logic [2*COORD_BITS+1:0] psq_o,
  output logic [2*COORD_BITS+1:0] quo_o
);

  localparam int unsigned QW = 2 * COORD_BITS + 2;

  logic [QW-1:0] rem_q [0:QW];
  logic [QW-1:0] low_q [0:QW];
  logic [QW-1:0] quo_q [0:QW];
  logic [QW-1:0] psq_q [0:QW];
  logic          out_q [0:QW];
  logic [QW:0]   vld_q;

  // Valid bits travel with the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-1:0], vld_i};
    end
  end

  // Load: high half is already below the divisor since the quotient fits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i[2*QW-1:QW];
      low_q[0] <= num_i[QW-1:0];
      quo_q[0] <= '0;
      psq_q[0] <= psq_i;
      out_q[0] <= outside_i;
    end
  end

  // Shift in one numerator bit, subtract where it goes
  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [QW:0] trial;
    logic        ge;
    assign trial = {rem_q[k], low_q[k][QW-1]};
    assign ge    = trial >= {1'b0, den_i};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? QW'(trial - {1'b0, den_i}) : trial[QW-1:0];
        low_q[k+1] <= {low_q[k][QW-2:0], 1'b0};
        quo_q[k+1] <= {quo_q[k][QW-2:0], ge};
        psq_q[k+1] <= psq_q[k];
        out_q[k+1] <= out_q[k];
      end
    end
  end

  assign vld_o     = vld_q[QW];
  assign outside_o = out_q[QW];
  assign psq_o     = psq_q[QW];
  assign quo_o     = quo_q[QW];

endmodule

// ===== dv/point_in_cylinder_test_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_in_cylinder_test_top_tb
// Self-checking bench for the streaming capped-cylinder membership test.
// ----------------------------------------------------------------------------
// Sets up a series of cylinders through the configuration channel, with the
// all-zero and the widest settings among them, and streams points at each.
// A short directed set is followed by random points, mostly near the axis.
// Each accepted point word is scored at once by an exact integer model of the
// test, and every result word is compared in order with the oldest prediction.
// Both stream sides idle at random. The receiver holds off once for a long
// stretch, and the sender waits for the pipeline to drain between cylinders.
module point_in_cylinder_test_top_tb;

  localparam int unsigned CB = 20;
  localparam int unsigned SQB = 2 * CB + 2;
  localparam int unsigned OUTB = 2 * CB + 3;
  localparam int unsigned DIN_W = ((3 * CB + 7) / 8) * 8;
  localparam int unsigned DOUT_W = ((2 * CB + 10) / 8) * 8;
  localparam int unsigned PIPE_LAT = 2 * CB + 10;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam longint POS_MAX = (longint'(1) <<< (OUTB - 1)) - 1;
  localparam longint NEG_MAX = longint'(1) <<< (OUTB - 1);
  localparam longint SQ_MAX = (longint'(1) <<< SQB) - 1;

  typedef struct packed {
    logic signed [CB-1:0] z;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] x;
  } point_t;

  typedef struct {
    logic              in_cyl;
    logic [OUTB-1:0]   dsq;
  } verdict_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // point_x, point_y, point_z
  logic [DIN_W-1:0]    s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // dist_sq
  logic [DOUT_W-1:0]   m_axis_tdata;
  // inside_res
  logic                m_axis_tuser;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [pic_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [SQB-1:0]      cfg_data_i = '0;

  // Cylinder registers as the block should hold them
  logic [SQB-1:0]      cyl_reg [8];
  point_t              point_q [$];
  verdict_t            verdict_q [$];
  int unsigned         err_cnt = 0;
  int unsigned         cyc_cnt = 0;
  int unsigned         word_cnt = 0;

  point_in_cylinder_test_top #(.COORD_BITS(CB)) uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Score one point against the current cylinder
  function automatic verdict_t classify_point(point_t p);
    longint   sx, sy, sz, dx, dy, dz, px, py, pz, dot, len, psq, quo, n;
    logic [127:0] dot2;
    verdict_t v;
    sx = longint'($signed(cyl_reg[pic_pkg::CFG_START_X][CB-1:0]));
    sy = longint'($signed(cyl_reg[pic_pkg::CFG_START_Y][CB-1:0]));
    sz = longint'($signed(cyl_reg[pic_pkg::CFG_START_Z][CB-1:0]));
    dx = longint'($signed(cyl_reg[pic_pkg::CFG_END_X][CB-1:0])) - sx;
    dy = longint'($signed(cyl_reg[pic_pkg::CFG_END_Y][CB-1:0])) - sy;
    dz = longint'($signed(cyl_reg[pic_pkg::CFG_END_Z][CB-1:0])) - sz;
    px = longint'(p.x) - sx;
    py = longint'(p.y) - sy;
    pz = longint'(p.z) - sz;
    len = longint'(cyl_reg[pic_pkg::CFG_LEN_SQ]);
    dot = px * dx + py * dy + pz * dz;
    v.in_cyl = 1'b0;
    v.dsq = '0;
    if (dot < 0 || dot > len) return v;
    psq = px * px + py * py + pz * pz;
    quo = 0;
    if (len != 0) begin
      dot2 = 128'(dot) * 128'(dot);
      quo = longint'(dot2 / 128'(len));
    end
    if (psq >= quo) begin
      v.in_cyl = (psq - quo) <= longint'(cyl_reg[pic_pkg::CFG_RADIUS]);
      v.dsq = OUTB'((psq - quo) > POS_MAX ? POS_MAX : psq - quo);
    end else begin
      n = quo - psq;
      v.in_cyl = 1'b1;
      v.dsq = OUTB'(-(n > NEG_MAX ? NEG_MAX : n));
    end
    if (!v.in_cyl) v.dsq = '0;
    return v;
  endfunction

  // Queue one point for the sender
  task automatic add_point(point_t p);
    point_q.insert(point_q.size(), p);
  endtask

  // Write one register over the configuration channel
  task automatic write_reg(pic_pkg::cfg_idx_e idx, logic [SQB-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cyl_reg[idx] = (idx == pic_pkg::CFG_LEN_SQ || idx == pic_pkg::CFG_RADIUS) ?
                   val : SQB'(val[CB-1:0]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_cylinder(point_t s, point_t e, logic [SQB-1:0] len,
                              logic [SQB-1:0] rad);
    write_reg(pic_pkg::CFG_START_X, SQB'(s.x));
    write_reg(pic_pkg::CFG_START_Y, SQB'(s.y));
    write_reg(pic_pkg::CFG_START_Z, SQB'(s.z));
    write_reg(pic_pkg::CFG_END_X, SQB'(e.x));
    write_reg(pic_pkg::CFG_END_Y, SQB'(e.y));
    write_reg(pic_pkg::CFG_END_Z, SQB'(e.z));
    write_reg(pic_pkg::CFG_LEN_SQ, len);
    write_reg(pic_pkg::CFG_RADIUS, rad);
  endtask

  // Hold the sender until the pipeline is empty, then let it settle
  task automatic drain();
    wait (point_q.size() == 0 && !s_axis_tvalid && verdict_q.size() == 0);
    repeat (PIPE_LAT + 8) @(posedge clk_i);
  endtask

  function automatic point_t any_point();
    return point_t'((3 * CB)'({$urandom, $urandom}));
  endfunction

  function automatic point_t mk_point(longint x, longint y, longint z);
    point_t p;
    p.x = CB'(x);
    p.y = CB'(y);
    p.z = CB'(z);
    return p;
  endfunction

  // Point at a random fraction along the axis plus a little scatter
  function automatic point_t near_axis(point_t s, point_t e, int unsigned spread);
    longint t;
    longint sp;
    t = $urandom_range(0, 1100);
    sp = longint'(spread);
    return mk_point(
      s.x + (longint'(e.x) - s.x) * t / 1024 + longint'($urandom_range(0, 2 * spread)) - sp,
      s.y + (longint'(e.y) - s.y) * t / 1024 + longint'($urandom_range(0, 2 * spread)) - sp,
      s.z + (longint'(e.z) - s.z) * t / 1024 + longint'($urandom_range(0, 2 * spread)) - sp);
  endfunction

  // Sender: idle gaps, bursts without gaps, score each accepted word
  int unsigned gap_cnt = 0;
  int unsigned burst_cnt = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        verdict_q.insert(verdict_q.size(),
                         classify_point(point_t'(s_axis_tdata[3*CB-1:0])));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_cnt > 0 || point_q.size() == 0) begin
          if (gap_cnt > 0) gap_cnt <= gap_cnt - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tdata <= DIN_W'(point_q.pop_front());
          s_axis_tvalid <= 1'b1;
          if (burst_cnt > 0) begin
            burst_cnt <= burst_cnt - 1;
            gap_cnt <= 0;
          end else if ($urandom_range(0, 49) == 0) begin
            burst_cnt <= $urandom_range(20, 60);
          end else begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4, 5: gap_cnt <= 0;
              6, 7, 8:          gap_cnt <= $urandom_range(1, 3);
              default:          gap_cnt <= $urandom_range(5, 30);
            endcase
          end
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off once results are flowing
  int unsigned hold_cnt = 0;
  bit          long_hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && word_cnt >= 300) begin
      long_hold_done <= 1'b1;
      hold_cnt <= 400;
      m_axis_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          hold_cnt <= $urandom_range(0, 3);
          m_axis_tready <= 1'b0;
        end
        3:       begin
          hold_cnt <= $urandom_range(10, 40);
          m_axis_tready <= 1'b0;
        end
        default: m_axis_tready <= 1'b1;
      endcase
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      word_cnt <= word_cnt + 1;
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result word inside=%0b dist=%h", $realtime,
                 m_axis_tuser, m_axis_tdata);
        err_cnt <= err_cnt + 1;
      end else begin
        verdict_t v;
        v = verdict_q.pop_front();
        if (m_axis_tuser !== v.in_cyl || m_axis_tdata !== DOUT_W'(v.dsq)) begin
          $display("%0t: mismatch: expected inside=%0b dist=%h, got inside=%0b dist=%h",
                   $realtime, v.in_cyl, DOUT_W'(v.dsq), m_axis_tuser, m_axis_tdata);
          err_cnt <= err_cnt + 1;
        end
      end
    end
  end

  // Run-away guard
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("point_in_cylinder_test_top verification failed");
      $finish;
    end
  end

  initial begin
    point_t s, e;
    longint dx, dy, dz, lsq;
    logic [SQB-1:0] len, rad;
    for (int i = 0; i < 8; i++) cyl_reg[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset cylinder: degenerate axis, zero length and radius
    add_point(mk_point(0, 0, 0));
    add_point(mk_point(1, 0, 0));
    add_point(mk_point(-524288, -524288, -524288));
    add_point(mk_point(524287, 524287, 524287));
    add_point(mk_point(-524288, 524287, 0));
    drain();

    // Axis along x, exact length: caps, rim, outside before and beyond
    set_cylinder(mk_point(0, 0, 0), mk_point(4096, 0, 0), 42'd16777216, 42'd1048576);
    add_point(mk_point(0, 0, 0));
    add_point(mk_point(4096, 0, 0));
    add_point(mk_point(-1, 0, 0));
    add_point(mk_point(4097, 0, 0));
    add_point(mk_point(2048, 1024, 0));
    add_point(mk_point(2048, 1025, 0));
    add_point(mk_point(2048, 0, -1024));
    add_point(mk_point(100, 524287, -524288));
    drain();

    // Short length register: one step along the axis is already past the far cap
    set_cylinder(mk_point(-100, 50, 0), mk_point(4000, 50, 0), 42'd4096, 42'd0);
    add_point(mk_point(-99, 50, 0));
    add_point(mk_point(-100, 50, 0));
    add_point(mk_point(-100, 51, 0));
    drain();

    // Widest cylinder: opposite corners, full length and radius
    set_cylinder(mk_point(-524288, -524288, -524288), mk_point(524287, 524287, 524287),
                 SQB'(SQ_MAX), SQB'(SQ_MAX));
    add_point(mk_point(524287, 524287, 524287));
    add_point(mk_point(524287, -524288, 524287));
    add_point(mk_point(0, 0, 0));
    add_point(mk_point(-524288, -524288, -524288));
    add_point(mk_point(-524288, 524287, 524287));
    drain();

    // Random cylinders, most points near the axis
    for (int ph = 0; ph < 8; ph++) begin
      s = any_point();
      e = any_point();
      if (ph % 3 == 1) begin
        s = mk_point(s.x >>> 6, s.y >>> 6, s.z >>> 6);
        e = mk_point(s.x + $signed($urandom_range(0, 8000)) - 4000,
                     s.y + $signed($urandom_range(0, 8000)) - 4000,
                     s.z + $signed($urandom_range(0, 8000)) - 4000);
      end
      dx = longint'(e.x) - s.x;
      dy = longint'(e.y) - s.y;
      dz = longint'(e.z) - s.z;
      lsq = dx * dx + dy * dy + dz * dz;
      case (ph % 4)
        0:       len = SQB'(lsq);
        1:       len = SQB'(lsq - (lsq >> $urandom_range(1, 8)));
        2:       len = SQB'({$urandom, $urandom});
        default: len = ph == 7 ? '0 : SQB'(lsq + $urandom_range(0, 1 << 20));
      endcase
      rad = ph == 5 ? SQB'(SQ_MAX) : SQB'(({$urandom, $urandom} & SQ_MAX) >> $urandom_range(0, 30));
      set_cylinder(s, e, len, rad);
      for (int k = 0; k < 175; k++) begin
        if ($urandom_range(0, 9) < 6)
          add_point(near_axis(s, e, 1 << $urandom_range(0, 18)));
        else
          add_point(any_point());
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("point_in_cylinder_test_top verification clean");
    end else begin
      $display("point_in_cylinder_test_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/pic_pkg.sv
rtl/core/pic_front.sv
rtl/core/pic_sqr.sv
rtl/core/pic_div.sv
rtl/core/point_in_cylinder_test_top.sv
dv/point_in_cylinder_test_top_tb.sv
